### hw/rtl/rwtm_pkg.sv
`default_nettype none
package rwtm_pkg;
    localparam int TILE_SIZE  = 64;
    localparam int TEX_HEIGHT = 64;
    localparam int TEX_LOG2   = $clog2(TEX_HEIGHT);
    localparam int TILE_LOG2  = $clog2(TILE_SIZE);
    localparam int QW         = 32;
    localparam int DW         = 24;
    localparam int NUM_DIV    = 32;
    localparam int YQ         = 24;
    localparam int NUM_Y      = 24;

    localparam logic [14:0] ANG_90  = 15'(90 * 64);
    localparam logic [14:0] ANG_180 = 15'(180 * 64);
    localparam logic [14:0] ANG_270 = 15'(270 * 64);
    localparam logic [14:0] ANG_360 = 15'(360 * 64);

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [23:0] distance;
        logic        side;
        logic [14:0] heading;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic [11:0] column;
        logic [11:0] row;
    } t_in;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        in_wall;
        logic [1:0]  texture_select;
        logic [5:0]  texel_x;
        logic [5:0]  texel_y;
    } t_out;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [1:0]  sel;
        logic [5:0]  tx;
        logic [11:0] sh;
    } t_side;

    // restoring divider cell payload
    typedef struct packed {
        logic        vld;
        logic [QW-1:0] rem;
        logic [QW-1:0] num;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
        logic        zero;
        t_side       sb;
    } t_hcell;

    typedef struct packed {
        logic          vld;
        logic [YQ-1:0] rem;
        logic [YQ-1:0] num;
        logic [15:0]   den;
        logic [5:0]    quo;
        logic          inw;
        t_side         sb;
    } t_ycell;
endpackage
`default_nettype wire

### hw/rtl/rwtm_stream_if.sv
`default_nettype none
interface rwtm_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/rwtm_hdiv_cell.sv
`default_nettype none
module rwtm_hdiv_cell
    import rwtm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_hcell i_c,
    output t_hcell      o_c
);
    t_hcell          r_c;
    logic [QW:0]     w_trial;
    logic [QW-1:0]   w_sh;
    always_comb begin
        w_sh    = {i_c.rem[QW-2:0], i_c.num[QW-1]};
        w_trial = {i_c.rem[QW-1], w_sh} - {{(QW-DW+1){1'b0}}, i_c.den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_c.vld <= i_c.vld;
        end
        if (i_en) begin
            r_c.num  <= {i_c.num[QW-2:0], 1'b0};
            r_c.den  <= i_c.den;
            r_c.zero <= i_c.zero;
            r_c.sb   <= i_c.sb;
            if (!w_trial[QW]) begin
                r_c.rem <= w_trial[QW-1:0];
                r_c.quo <= {i_c.quo[QW-2:0], 1'b1};
            end else begin
                r_c.rem <= w_sh;
                r_c.quo <= {i_c.quo[QW-2:0], 1'b0};
            end
        end
    end
    assign o_c = r_c;
endmodule
`default_nettype wire

### hw/rtl/rwtm_ydiv_cell.sv
`default_nettype none
module rwtm_ydiv_cell
    import rwtm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_ycell i_c,
    output t_ycell      o_c
);
    t_ycell          r_c;
    logic [YQ:0]     w_trial;
    logic [YQ-1:0]   w_sh;
    always_comb begin
        w_sh    = {i_c.rem[YQ-2:0], i_c.num[YQ-1]};
        w_trial = {1'b0, w_sh} - {{(YQ-15){1'b0}}, i_c.den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_c.vld <= i_c.vld;
        end
        if (i_en) begin
            r_c.num <= {i_c.num[YQ-2:0], 1'b0};
            r_c.den <= i_c.den;
            r_c.inw <= i_c.inw;
            r_c.sb  <= i_c.sb;
            if (!w_trial[YQ]) begin
                r_c.rem <= w_trial[YQ-1:0];
                r_c.quo <= {i_c.quo[4:0], 1'b1};
            end else begin
                r_c.rem <= w_sh;
                r_c.quo <= {i_c.quo[4:0], 1'b0};
            end
        end
    end
    assign o_c = r_c;
endmodule
`default_nettype wire

### hw/rtl/raycast_wall_texel_mapper_top.sv
`default_nettype none
// channel | dir | payload
// s_in    | in  | t_in  (distance, side, heading, hit_x, hit_y, column, row)
// m_out   | out | t_out (pixel_x, pixel_y, in_wall, texture_select, texel_x, texel_y)
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// One item per cycle while the output is not stalled; the chain is 32 height-divider cells, a span
// stage, 24 texel-row divider cells and the output register.
// Whole chain advances together; it stalls only while a finished item waits
// at the output. Reset clears valid bits and loads register defaults.
module raycast_wall_texel_mapper_top
    import rwtm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  [1:0] i_cfg_idx,
    input  wire logic  [31:0] i_cfg_data,
    rwtm_stream_if.sink   s_in,
    rwtm_stream_if.source m_out
);
    logic [31:0] r_scale;
    logic [11:0] r_sh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 32'd9081600;
            r_sh    <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE:  r_scale <= i_cfg_data;
                REG_HEIGHT: r_sh    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    t_out r_out;
    logic r_ov;
    t_in  w_in;
    assign w_in = t_in'(s_in.data);
    assign w_en = !r_ov || m_out.ready;
    assign s_in.ready = w_en;

    t_side  w_sb;
    t_hcell w_h [NUM_DIV+1];
    always_comb begin
        w_sb.column = w_in.column;
        w_sb.row    = w_in.row;
        w_sb.sh     = r_sh;
        w_sb.tx     = w_in.side ? w_in.hit_y[TILE_LOG2-1:0] : w_in.hit_x[TILE_LOG2-1:0];
        if (!w_in.side)
            w_sb.sel = (w_in.heading > ANG_180 && w_in.heading < ANG_360) ? 2'd1 : 2'd0;
        else
            w_sb.sel = (w_in.heading > ANG_90 && w_in.heading < ANG_270) ? 2'd3 : 2'd2;
        w_h[0].vld  = s_in.valid;
        w_h[0].rem  = '0;
        w_h[0].num  = r_scale;
        w_h[0].den  = w_in.distance;
        w_h[0].quo  = '0;
        w_h[0].zero = (w_in.distance == '0);
        w_h[0].sb   = w_sb;
    end
    for (genvar g = 0; g < NUM_DIV; g++) begin : g_h
        rwtm_hdiv_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_c(w_h[g]), .o_c(w_h[g+1]));
    end

    // span stage
    t_hcell      w_hl;
    logic [15:0] w_h16;
    logic [12:0] w_half, w_top_l, w_bot;
    logic [16:0] w_sum;
    logic signed [18:0] w_top, w_dft;
    logic        w_inw;
    always_comb begin
        w_hl   = w_h[NUM_DIV];
        w_h16  = (w_hl.zero || w_hl.quo > 32'd65535) ? 16'hFFFF : w_hl.quo[15:0];
        w_half = {2'b0, w_hl.sb.sh[11:1]};
        w_top  = 19'(signed'({6'b0, w_half})) - 19'(signed'({2'b0, 17'(w_h16) + 17'd1} >>> 1));
        w_top  = (w_top < 0) ? 19'sd0 : w_top;
        w_sum  = {4'b0, w_half} + {2'b0, w_h16[15:1]};
        w_bot  = (w_sum > {5'b0, w_hl.sb.sh}) ? {1'b0, w_hl.sb.sh} : w_sum[12:0];
        w_top_l = w_top[12:0];
        w_inw  = ({1'b0, w_hl.sb.row} >= w_top_l) && ({1'b0, w_hl.sb.row} < w_bot)
                 && (w_h16 != 16'd0);
        w_dft  = 19'(signed'({7'b0, w_hl.sb.row})) + 19'(signed'({3'b0, w_h16[15:1]}))
                 - 19'(signed'({6'b0, w_half}));
        if (w_dft < 0) w_dft = 19'sd0;
    end
    t_ycell r_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.vld <= 1'b0;
        end else if (w_en) begin
            r_s.vld <= w_hl.vld;
        end
        if (w_en) begin
            r_s.rem <= '0;
            r_s.num <= YQ'({w_dft[17:0], {TEX_LOG2{1'b0}}});
            r_s.den <= (w_h16 == 16'd0) ? 16'd1 : w_h16;
            r_s.quo <= '0;
            r_s.inw <= w_inw;
            r_s.sb  <= w_hl.sb;
        end
    end

    t_ycell w_y [NUM_Y+1];
    assign w_y[0] = r_s;
    for (genvar g = 0; g < NUM_Y; g++) begin : g_y
        rwtm_ydiv_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_c(w_y[g]), .o_c(w_y[g+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_y[NUM_Y].vld;
        end
        if (w_en) begin
            r_out.pixel_x        <= w_y[NUM_Y].sb.column;
            r_out.pixel_y        <= w_y[NUM_Y].sb.row;
            r_out.in_wall        <= w_y[NUM_Y].inw;
            r_out.texture_select <= w_y[NUM_Y].sb.sel;
            r_out.texel_x        <= w_y[NUM_Y].sb.tx;
            r_out.texel_y        <= w_y[NUM_Y].inw ? w_y[NUM_Y].quo : 6'd0;
        end
    end
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire
